[src/assert_macros.svh]
// Assertion macros used by the checker in hsfc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Non-overlapping implication, with the consequent checked after the antecedent, outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[src/hsfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfc_pkg
// Types, constants and register indexes of the HDR sample converter.
// ----------------------------------------------------------------------------
package hsfc_pkg;

   localparam logic [2:0] REG_SAMPLE_TYPE = 3'd0;
   localparam logic [2:0] REG_RED_INDEX   = 3'd1;
   localparam logic [2:0] REG_GREEN_INDEX = 3'd2;
   localparam logic [2:0] REG_BLUE_INDEX  = 3'd3;
   localparam logic [2:0] REG_ALPHA_INDEX = 3'd4;

   typedef enum logic [2:0] {
      ST_HALF  = 3'd0,
      ST_FLOAT = 3'd1,
      ST_Q2_13 = 3'd2,
      ST_Q7_24 = 3'd3,
      ST_RGBE  = 3'd4
   } sample_type_type;

   localparam logic [31:0] OPAQUE_ONE = 32'h3F80_0000;
   localparam logic [31:0] QNAN_BITS  = 32'h7FC0_0000;
   localparam logic [31:0] INF_BITS   = 32'h7F80_0000;

endpackage

[src/hdr_sample_to_float32_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdr_sample_to_float32_converter
// Converts one pixel of four raw sample words to four binary32 channels.
// ----------------------------------------------------------------------------
// Channel  Direction  Content
// req      in         word0..word3
// rsp      out        red, green, blue, alpha bits
// csr      in         register writes
// An accepted pixel is held in the result register, which drives the response.
// One pixel is accepted every cycle unless a full result register is stalled; it is the only stage.
// A stalled result holds while a new word waits at the input.
// Reset is synchronous and resets the valid flag and the CSRs, not the result data.
module hdr_sample_to_float32_converter (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // word0, word1, word2, word3
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // red_bits, green_bits, blue_bits, alpha_bits
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [2:0]   csr_wdata
);

   logic [2:0]   type_ff;
   logic [1:0]   red_ff, green_ff, blue_ff;
   logic [2:0]   alpha_ff;
   logic         valid_ff;
   logic [127:0] data_ff;
   logic [127:0] data_in;
   logic [31:0]  words [4];
   logic [31:0]  lane_out [4];
   logic [1:0]   sel [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff  <= 3'd0;
         red_ff   <= 2'd0;
         green_ff <= 2'd1;
         blue_ff  <= 2'd2;
         alpha_ff <= 3'd4;
      end else if (csr_we) begin
         case (csr_index)
            hsfc_pkg::REG_SAMPLE_TYPE: type_ff  <= csr_wdata;
            hsfc_pkg::REG_RED_INDEX:   red_ff   <= csr_wdata[1:0];
            hsfc_pkg::REG_GREEN_INDEX: green_ff <= csr_wdata[1:0];
            hsfc_pkg::REG_BLUE_INDEX:  blue_ff  <= csr_wdata[1:0];
            hsfc_pkg::REG_ALPHA_INDEX: alpha_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = !valid_ff || rsp_tready;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         words[i] = req_tdata[32*i +: 32];
      end
      sel[0] = red_ff;
      sel[1] = green_ff;
      sel[2] = blue_ff;
      sel[3] = alpha_ff[1:0];
   end

   for (genvar g = 0; g < 4; g++) begin : g_lane
      hsfc_lane u_lane (
         .sample_type (type_ff),
         .word        (words[sel[g]]),
         .shared_exp  (words[3][7:0]),
         .result      (lane_out[g])
      );
   end

   assign data_in = {(alpha_ff[2] ? hsfc_pkg::OPAQUE_ONE : lane_out[3]),
                     lane_out[2], lane_out[1], lane_out[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

[src/hsfc_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfc_lane
// Converts one selected sample word to a binary32 bit pattern.
// ----------------------------------------------------------------------------
module hsfc_lane (
   input  logic [2:0]  sample_type,
   input  logic [31:0] word,
   input  logic [7:0]  shared_exp,
   output logic [31:0] result
);

   logic [31:0] mag;
   logic        neg;
   logic [4:0]  lead;
   logic [4:0]  sh;
   logic [31:0] norm;
   logic        sticky;
   logic [24:0] mant;
   logic [8:0]  bexp;
   logic [31:0] rnd_out;
   logic [31:0] half_out;
   logic [4:0]  he;
   logic [9:0]  hm;
   logic [8:0]  rexp;
   logic [31:0] rgbe_out;
   logic [7:0]  rm;
   logic [3:0]  lz8;

   // Magnitude and sign for the fixed-point and binary16 paths.
   always_comb begin
      he  = word[14:10];
      hm  = word[9:0];
      neg = 1'b0;
      mag = 32'd0;
      case (sample_type)
         hsfc_pkg::ST_HALF: begin
            neg = word[15];
            mag = {21'd0, (he != 5'd0), hm};
         end
         hsfc_pkg::ST_Q2_13: begin
            neg = word[15];
            mag = neg ? {16'd0, 16'(16'd0 - word[15:0])} : {16'd0, word[15:0]};
         end
         hsfc_pkg::ST_Q7_24: begin
            neg = word[31];
            mag = neg ? (32'd0 - word) : word;
         end
         default: begin
            neg = 1'b0;
            mag = 32'd0;
         end
      endcase
   end

   always_comb begin
      lead = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (mag[i]) begin
            lead = 5'(i);
         end
      end
   end

   // Biased exponent of the leading one: lead + scale + 127.
   always_comb begin
      sh     = 5'd31 - lead;
      norm   = mag << sh;
      sticky = |norm[6:0];
      mant   = {1'b0, norm[31:8]} + {24'd0, norm[7] & (sticky | norm[8])};
      if (sample_type == hsfc_pkg::ST_HALF) begin
         bexp = (he == 5'd0) ? 9'(9'd103 + lead) : 9'(9'd102 + lead + he);
      end else if (sample_type == hsfc_pkg::ST_Q2_13) begin
         bexp = 9'(9'd114 + lead);
      end else begin
         bexp = 9'(9'd103 + lead);
      end
      if (mant[24]) begin
         bexp = bexp + 9'd1;
      end
      rnd_out = (mag == 32'd0) ? {neg, 31'd0}
              : {neg, bexp[7:0], (mant[24] ? mant[23:1] : mant[22:0])};
      half_out = (he == 5'd31) ? (hm != 10'd0 ? {neg, hsfc_pkg::QNAN_BITS[30:0]}
                                              : {neg, hsfc_pkg::INF_BITS[30:0]})
                                : rnd_out;
   end

   // RGBE: value = rm * 2^(exp - 136). Small exponents give exact subnormals.
   always_comb begin
      rm  = word[7:0];
      lz8 = 4'd0;
      for (int i = 0; i < 8; i++) begin
         if (rm[i]) begin
            lz8 = 4'(i);
         end
      end
      rexp = 9'({1'b0, shared_exp} + {5'd0, lz8}) - 9'd9;
      if (shared_exp == 8'd0 || rm == 8'd0) begin
         rgbe_out = 32'd0;
      end else if (rexp[8] || rexp == 9'd0) begin
         rgbe_out = {9'd0, 23'({24'd0, rm} << (shared_exp[4:0] + 5'd13))};
      end else begin
         rgbe_out = {1'b0, rexp[7:0], 23'({24'd0, rm} << (5'd23 - {1'b0, lz8}))};
      end
   end

   always_comb begin
      case (sample_type)
         hsfc_pkg::ST_HALF:  result = half_out;
         hsfc_pkg::ST_FLOAT: result = word;
         hsfc_pkg::ST_Q2_13: result = rnd_out;
         hsfc_pkg::ST_Q7_24: result = rnd_out;
         hsfc_pkg::ST_RGBE:  result = rgbe_out;
         default:            result = 32'd0;
      endcase
   end

endmodule

[src/hsfc_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// hsfc_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsfc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata
);

   `CHK_IMPLY(a_ready_free, clock, reset, !rsp_tvalid, req_tready, "not ready while empty")
   `CHK_NEXT(a_word_out, clock, reset, req_tvalid && req_tready, rsp_tvalid, "word lost")
   `CHK_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "data moved")

endmodule

bind hdr_sample_to_float32_converter hsfc_checker u_hsfc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[bench/hdr_sample_to_float32_converter_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdr_sample_to_float32_converter_checker
// Watches the request and response channels and the register writes of the
// converter, predicts each pixel's four binary32 channels from the accepted
// request word and compares them, in order, with the response words.
// ----------------------------------------------------------------------------
module hdr_sample_to_float32_converter_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [127:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [2:0]   csr_wdata,
   output int           fail_count,
   output int           pending_pixels
);

   logic [2:0] cur_type;
   logic [1:0] red_sel, green_sel, blue_sel;
   logic [2:0] alpha_sel;
   logic [127:0] pixel_queue[$];

   function automatic logic [63:0] round_shift(logic [63:0] x, int n);
      logic [63:0] q, rem, half;
      if (n <= 0) return x;
      if (n >= 64) return 64'd0;
      q = x >> n;
      rem = x & ((64'd1 << n) - 64'd1);
      half = 64'd1 << (n - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      return q;
   endfunction

   function automatic logic [31:0] pack_float(bit neg, logic [63:0] mag, int scale);
      logic [31:0] sgn;
      int top, bexp, s;
      logic [63:0] m;
      sgn = neg ? 32'h8000_0000 : 32'd0;
      if (mag == 64'd0) return sgn;
      top = 0;
      while (top < 63 && (mag >> (top + 1)) != 64'd0) top++;
      bexp = top + scale + 127;
      if (bexp >= 1) begin
         m = (top > 23) ? round_shift(mag, top - 23) : (mag << (23 - top));
         if ((m >> 24) != 64'd0) begin
            m = m >> 1;
            bexp++;
         end
         if (bexp >= 255) return sgn | hsfc_pkg::INF_BITS;
         return sgn | (32'(bexp) << 23) | (m[31:0] & 32'h007F_FFFF);
      end
      s = scale + 149;
      m = (s >= 0) ? (mag << s) : round_shift(mag, -s);
      return sgn | m[31:0];
   endfunction

   function automatic logic [31:0] half_to_single(logic [15:0] h);
      logic [4:0] e;
      logic [9:0] m;
      e = h[14:10];
      m = h[9:0];
      if (e == 5'd0) return pack_float(h[15], 64'(m), -24);
      if (e != 5'h1f) return pack_float(h[15], 64'({1'b1, m}), int'(e) - 25);
      return {h[15], 31'd0} | ((m != 10'd0) ? hsfc_pkg::QNAN_BITS : hsfc_pkg::INF_BITS);
   endfunction

   function automatic logic [31:0] lane_value(logic [127:0] px, logic [1:0] sel);
      logic [31:0] w;
      logic [15:0] v;
      logic [63:0] mag;
      w = px[32*sel +: 32];
      case (cur_type)
         hsfc_pkg::ST_HALF: return half_to_single(w[15:0]);
         hsfc_pkg::ST_FLOAT: return w;
         hsfc_pkg::ST_Q2_13: begin
            v = w[15:0];
            mag = v[15] ? 64'(16'(-v)) : 64'(v);
            if (v[15] && mag == 64'd0) mag = 64'h8000;
            return pack_float(v[15], mag, -13);
         end
         hsfc_pkg::ST_Q7_24: begin
            mag = w[31] ? (64'h1_0000_0000 - 64'(w)) : 64'(w);
            return pack_float(w[31], mag, -24);
         end
         hsfc_pkg::ST_RGBE: begin
            if (px[103:96] == 8'd0) return 32'd0;
            return pack_float(1'b0, 64'(w[7:0]), int'(px[103:96]) - 136);
         end
         default: return 32'd0;
      endcase
   endfunction

   function automatic logic [127:0] convert_pixel(logic [127:0] px);
      logic [31:0] a;
      a = (alpha_sel >= 3'd4) ? hsfc_pkg::OPAQUE_ONE : lane_value(px, alpha_sel[1:0]);
      return {a, lane_value(px, blue_sel), lane_value(px, green_sel),
              lane_value(px, red_sel)};
   endfunction

   assign pending_pixels = pixel_queue.size();

   always @(posedge clock) begin
      logic [127:0] want;
      if (reset) begin
         cur_type <= hsfc_pkg::ST_HALF;
         red_sel <= 2'd0;
         green_sel <= 2'd1;
         blue_sel <= 2'd2;
         alpha_sel <= 3'd4;
         fail_count <= 0;
         pixel_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pixel_queue.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = pixel_queue.pop_front();
               for (int k = 0; k < 4; k++)
                  if (want[32*k +: 32] !== rsp_tdata[32*k +: 32])
                     $display("%0t: lane %0d expected %h actual %h", $time, k,
                              want[32*k +: 32], rsp_tdata[32*k +: 32]);
               if (want !== rsp_tdata) fail_count <= fail_count + 1;
            end
         end
         if (req_tvalid && req_tready) pixel_queue.push_back(convert_pixel(req_tdata));
         if (csr_we) begin
            case (csr_index)
               hsfc_pkg::REG_SAMPLE_TYPE: cur_type <= csr_wdata;
               hsfc_pkg::REG_RED_INDEX: red_sel <= csr_wdata[1:0];
               hsfc_pkg::REG_GREEN_INDEX: green_sel <= csr_wdata[1:0];
               hsfc_pkg::REG_BLUE_INDEX: blue_sel <= csr_wdata[1:0];
               hsfc_pkg::REG_ALPHA_INDEX: alpha_sel <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

[bench/hdr_sample_to_float32_converter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdr_sample_to_float32_converter_test
// Drives directed and random pixels through the converter under every sample
// type and several channel mappings, with random idle bursts on both sides;
// the checker predicts and compares each response.
// ----------------------------------------------------------------------------
module hdr_sample_to_float32_converter_test;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;
   logic         csr_we;
   logic [2:0]   csr_index;
   logic [2:0]   csr_wdata;
   int           fail_count;
   int           pending_pixels;
   bit           calm_phase;

   hdr_sample_to_float32_converter u_dut (.*);

   hdr_sample_to_float32_converter_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("hdr_sample_to_float32_converter test failed");
      $finish;
   end

   // Response side backpressure in random bursts.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         if (!calm_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [2:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_pixels != 0 || rsp_tvalid) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic send_pixel(logic [127:0] px);
      if (!calm_phase && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word(logic [2:0] st);
      logic [31:0] w;
      w = $urandom();
      case ($urandom_range(0, 7))
         0: w[15:0] = {w[15], 5'h1f, w[9:0]};
         1: w[15:0] = {w[15], 5'h00, w[9:0]};
         2: w = {w[31], 31'd0};
         3: w[7:0] = (st == hsfc_pkg::ST_RGBE) ? 8'd0 : w[7:0];
         4: w[7:0] = 8'($urandom_range(0, 12));
         default: ;
      endcase
      return w;
   endfunction

   logic [31:0] special[12] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_8000,
      32'h0000_7C00, 32'h0000_FC00, 32'h0000_7E01, 32'h0000_FC01, 32'h0000_0001,
      32'h0000_03FF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_00FF};

   logic [2:0] types[6] = '{hsfc_pkg::ST_HALF, hsfc_pkg::ST_FLOAT, hsfc_pkg::ST_Q2_13,
      hsfc_pkg::ST_Q7_24, hsfc_pkg::ST_RGBE, 3'd7};

   initial begin
      logic [2:0] st;
      reset = 1'b1;
      calm_phase = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: special words under every type, with alpha from word 3 or set to one.
      foreach (types[t]) begin
         write_reg(hsfc_pkg::REG_SAMPLE_TYPE, types[t]);
         write_reg(hsfc_pkg::REG_ALPHA_INDEX, (t % 2) ? 3'd3 : 3'd7);
         for (int k = 0; k < 12; k += 4)
            send_pixel({special[k+3], special[k+2], special[k+1], special[k]});
         send_pixel({32'h0000_0001, special[11], special[1], special[7]});
         settle();
      end
      // Random phases, each with a fresh register setting.
      for (int ph = 0; ph < 32; ph++) begin
         if (ph == 28) calm_phase = 1'b1;
         st = (ph < 24) ? 3'(ph % 5) : 3'($urandom_range(0, 7));
         write_reg(hsfc_pkg::REG_SAMPLE_TYPE, st);
         write_reg(hsfc_pkg::REG_RED_INDEX, 3'($urandom_range(0, 7)));
         write_reg(hsfc_pkg::REG_GREEN_INDEX, 3'($urandom_range(0, 7)));
         write_reg(hsfc_pkg::REG_BLUE_INDEX, 3'($urandom_range(0, 7)));
         write_reg(hsfc_pkg::REG_ALPHA_INDEX, 3'($urandom_range(0, 7)));
         repeat (25)
            send_pixel({rand_word(st), rand_word(st), rand_word(st), rand_word(st)});
         settle();
      end
      settle();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_pixels == 0) begin
         $display("hdr_sample_to_float32_converter test passed");
      end else begin
         $display("hdr_sample_to_float32_converter test failed");
      end
      $finish;
   end

endmodule

[hdr_sample_to_float32_converter.f]
+incdir+src
src/hsfc_pkg.sv
src/hsfc_lane.sv
src/hdr_sample_to_float32_converter.sv
src/hsfc_checker.sv
bench/hdr_sample_to_float32_converter_checker.sv
bench/hdr_sample_to_float32_converter_test.sv
